>>> rtl/wssa_pkg.sv
package wssa_pkg;

	// Array geometry and data widths.
	localparam int ARRAY_DIM_DEF = 8;
	localparam int BYTES_PER_WORD = 4;
	localparam int BYTE_W = 8;
	localparam int ACC_W = 32;
	localparam int WORD_W = BYTES_PER_WORD * BYTE_W;
	localparam int IDX_W = 6;
	localparam int LANE_W = $clog2(BYTES_PER_WORD);

	// Command codes.
	localparam logic [1:0] CMD_WRITE_WEIGHTS = 2'd0;
	localparam logic [1:0] CMD_QUEUE_GROUP = 2'd1;
	localparam logic [1:0] CMD_STREAM_STEP = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [IDX_W-1:0] weight_index;
		logic column_group;
		logic [WORD_W-1:0] data_word;
	} cmd_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic nonzero_tile;
	} rsp_item_t;

	// Control for one multiply-accumulate cell.
	typedef struct packed {
		logic step;
		logic w_we;
		logic [BYTE_W-1:0] w_byte;
	} cell_ctl_t;

	// Control for one row of the input skew buffer.
	typedef struct packed {
		logic shift;
		logic wr_en;
		logic [BYTE_W-1:0] wr_byte;
	} skew_ctl_t;

	// Byte lane of a packed word; lane 0 sits in the most significant byte.
	function automatic logic [BYTE_W-1:0] byte_of(input logic [WORD_W-1:0] word,
			input logic [LANE_W-1:0] lane);
		return word[(BYTES_PER_WORD - 1 - int'(lane)) * BYTE_W +: BYTE_W];
	endfunction

endpackage

>>> rtl/wssa_cell.sv
module wssa_cell #(
	parameter bit FIRST_COL = 1'b0
) (
	input logic clk,
	input logic arst_n,
	input wssa_pkg::cell_ctl_t ctl,
	input logic signed [wssa_pkg::BYTE_W-1:0] x_in,
	output logic signed [wssa_pkg::BYTE_W-1:0] x_out,
	input logic [wssa_pkg::ACC_W-1:0] psum_in,
	output logic [wssa_pkg::ACC_W-1:0] psum_out,
	output logic [wssa_pkg::ACC_W-1:0] sum_nxt
);

	logic signed [wssa_pkg::BYTE_W-1:0] w_q;
	logic signed [wssa_pkg::BYTE_W-1:0] x_q;
	logic [wssa_pkg::ACC_W-1:0] ps_q;
	logic signed [2*wssa_pkg::BYTE_W-1:0] prod;

	// The first column multiplies the byte arriving from the skew buffer;
	// the others use the byte held from the previous step.
	assign x_out = FIRST_COL ? x_in : x_q;

	// Signed multiply, sign-extend, and add the partial sum from above.
	assign prod = x_out * w_q;
	assign sum_nxt = psum_in + wssa_pkg::ACC_W'(prod);
	assign psum_out = ps_q;

	// Weight, input and partial sum registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
			x_q <= '0;
			ps_q <= '0;
		end else begin
			if (ctl.w_we) begin
				w_q <= ctl.w_byte;
			end
			if (ctl.step) begin
				x_q <= x_in;
				ps_q <= sum_nxt;
			end
		end
	end

endmodule

>>> rtl/wssa_skew_row.sv
module wssa_skew_row #(
	parameter int DEPTH = wssa_pkg::ARRAY_DIM_DEF,
	parameter bit HOLD_LEFT = 1'b1
) (
	input logic clk,
	input logic arst_n,
	input wssa_pkg::skew_ctl_t ctl,
	output logic signed [wssa_pkg::BYTE_W-1:0] feed
);

	logic [wssa_pkg::BYTE_W-1:0] q [DEPTH];
	logic [wssa_pkg::BYTE_W-1:0] eff [DEPTH];

	// Contents after a write to the entry point, before any shift.
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			eff[k] = q[k];
		end
		if (ctl.wr_en) begin
			eff[0] = ctl.wr_byte;
		end
	end

	// The last entry drives the array's first column.
	assign feed = eff[DEPTH-1];

	// Shift toward the array; the entry point keeps its byte only on the
	// row whose entry point is the buffer's leftmost column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				q[k] <= '0;
			end
		end else if (ctl.shift) begin
			q[0] <= HOLD_LEFT ? eff[0] : '0;
			for (int k = 1; k < DEPTH; k++) begin
				q[k] <= eff[k-1];
			end
		end else if (ctl.wr_en) begin
			q[0] <= ctl.wr_byte;
		end
	end

endmodule

>>> rtl/wssa_deskew_col.sv
module wssa_deskew_col #(
	parameter int DEPTH = wssa_pkg::ARRAY_DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input logic [wssa_pkg::BYTE_W-1:0] in_byte,
	output logic [wssa_pkg::BYTE_W-1:0] rd_nxt
);

	logic [wssa_pkg::BYTE_W-1:0] q [DEPTH];

	// Shift line: new bottom-row byte enters at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				q[k] <= '0;
			end
		end else if (shift) begin
			q[0] <= in_byte;
			for (int k = 1; k < DEPTH; k++) begin
				q[k] <= q[k-1];
			end
		end
	end

	// Value of the read-out entry once this cycle's update has taken place.
	generate
		if (DEPTH == 1) begin : g_single
			assign rd_nxt = shift ? in_byte : q[0];
		end else begin : g_multi
			assign rd_nxt = shift ? q[DEPTH-2] : q[DEPTH-1];
		end
	endgenerate

endmodule

>>> rtl/weight_stationary_systolic_mac_array.sv
// Weight-stationary int8 systolic multiply-accumulate array.
//
// Command channel (cmd_valid/cmd_ready/cmd) takes one transaction per item:
// a weight write, an input column group queued into the skew buffer, or a
// stream step that advances every cell of the array at once. Each command
// produces exactly one transaction on the response channel
// (rsp_valid/rsp_ready/rsp) in the same order.
// A response is registered when its command is accepted, and the block
// sustains one command per cycle while the response side is not stalled:
// every cell has its own multiplier and accumulator.
// The response side has an output register plus one skid entry. When the
// receiver stalls, one more command is still accepted into the skid entry;
// cmd_ready then drops until the output register drains.
// Reset clears the weights, the skew and deskew buffers, all partial sums,
// the nonzero-tile flag and the valid bits of both response entries. The
// block is ready once reset is released.
module weight_stationary_systolic_mac_array #(
	parameter int ARRAY_DIM = wssa_pkg::ARRAY_DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input wssa_pkg::cmd_item_t cmd,
	output logic rsp_valid,
	input logic rsp_ready,
	output wssa_pkg::rsp_item_t rsp
);

	localparam int BPW = wssa_pkg::BYTES_PER_WORD;
	localparam int BW = wssa_pkg::BYTE_W;
	localparam int NGROUPS = ARRAY_DIM / BPW;
	localparam int WIX_W = wssa_pkg::IDX_W + 1;
	localparam int WR_LIMIT = 2 ** wssa_pkg::IDX_W + BPW - 1;

	logic cmd_fire;
	logic is_write;
	logic is_queue;
	logic is_step;

	logic signed [BW-1:0] feed_w [ARRAY_DIM];
	logic signed [BW-1:0] x_w [ARRAY_DIM][ARRAY_DIM];
	logic [wssa_pkg::ACC_W-1:0] ps_w [ARRAY_DIM+1][ARRAY_DIM];
	logic [wssa_pkg::ACC_W-1:0] bot_sum_w [ARRAY_DIM];
	logic [BW-1:0] rd_w [ARRAY_DIM];

	logic flag_q;
	logic flag_nxt;
	logic [1:0] grp_inc;
	logic [1:0] rd_grp;
	logic [wssa_pkg::WORD_W-1:0] res_word;
	wssa_pkg::rsp_item_t rsp_nxt;

	wssa_pkg::rsp_item_t out_q;
	wssa_pkg::rsp_item_t skid_q;
	logic out_vld_q;
	logic skid_vld_q;

	// Command decode.
	assign cmd_ready = ~skid_vld_q;
	assign cmd_fire = cmd_valid & cmd_ready;
	assign is_write = (cmd.command == wssa_pkg::CMD_WRITE_WEIGHTS);
	assign is_queue = (cmd.command == wssa_pkg::CMD_QUEUE_GROUP);
	assign is_step = (cmd.command == wssa_pkg::CMD_STREAM_STEP);

	// Input skew buffer: row r enters at column ARRAY_DIM-1-r.
	generate
		for (genvar r = 0; r < ARRAY_DIM; r++) begin : g_skew
			localparam int GRP = r / BPW;
			localparam int LANE = r % BPW;
			localparam bit LAST = (GRP == NGROUPS - 1);
			logic q_hit;
			wssa_pkg::skew_ctl_t sctl;

			if (GRP < 2) begin : g_q
				assign q_hit = (cmd.column_group == 1'(GRP));
			end else begin : g_nq
				assign q_hit = 1'b0;
			end

			assign sctl.shift = cmd_fire & is_step;
			assign sctl.wr_en = cmd_fire & ((is_queue & q_hit) | (is_step & LAST));
			assign sctl.wr_byte = cmd.data_word[(BPW - 1 - LANE) * BW +: BW];

			wssa_skew_row #(
				.DEPTH(r + 1),
				.HOLD_LEFT(r == ARRAY_DIM - 1)
			) u_skew (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(sctl),
				.feed(feed_w[r])
			);
		end
	endgenerate

	// Cell grid: inputs flow right, partial sums flow down.
	generate
		for (genvar c = 0; c < ARRAY_DIM; c++) begin : g_top
			assign ps_w[0][c] = '0;
		end
		for (genvar r = 0; r < ARRAY_DIM; r++) begin : g_row
			for (genvar c = 0; c < ARRAY_DIM; c++) begin : g_col
				localparam int POS = r * ARRAY_DIM + c;
				wssa_pkg::cell_ctl_t cctl;
				logic signed [BW-1:0] x_left;
				logic [wssa_pkg::ACC_W-1:0] sum_c;

				// Weight write decode for this cell's row-major position.
				if (POS < WR_LIMIT) begin : g_wr
					logic [WIX_W-1:0] wdiff;
					assign wdiff = WIX_W'(POS) - {1'b0, cmd.weight_index};
					assign cctl.w_we = cmd_fire & is_write
						& ({1'b0, cmd.weight_index} <= WIX_W'(POS))
						& (wdiff < WIX_W'(BPW));
					assign cctl.w_byte = wssa_pkg::byte_of(cmd.data_word,
						wdiff[wssa_pkg::LANE_W-1:0]);
				end else begin : g_nwr
					assign cctl.w_we = 1'b0;
					assign cctl.w_byte = '0;
				end
				assign cctl.step = cmd_fire & is_step;

				if (c == 0) begin : g_first
					assign x_left = feed_w[r];
				end else begin : g_next
					assign x_left = x_w[r][c-1];
				end

				wssa_cell #(
					.FIRST_COL(c == 0)
				) u_cell (
					.clk(clk),
					.arst_n(arst_n),
					.ctl(cctl),
					.x_in(x_left),
					.x_out(x_w[r][c]),
					.psum_in(ps_w[r][c]),
					.psum_out(ps_w[r+1][c]),
					.sum_nxt(sum_c)
				);

				if (r == ARRAY_DIM - 1) begin : g_bot
					assign bot_sum_w[c] = sum_c;
				end
			end
		end
	endgenerate

	// Output deskew buffer: column c is read at row ARRAY_DIM-1-c.
	generate
		for (genvar c = 0; c < ARRAY_DIM; c++) begin : g_deskew
			wssa_deskew_col #(
				.DEPTH(ARRAY_DIM - c)
			) u_deskew (
				.clk(clk),
				.arst_n(arst_n),
				.shift(cmd_fire & is_step),
				.in_byte(bot_sum_w[c][BW-1:0]),
				.rd_nxt(rd_w[c])
			);
		end
	endgenerate

	// Group read back: the next group after a queue, group 0 after a step.
	assign grp_inc = {1'b0, cmd.column_group} + 2'd1;
	always_comb begin
		if (is_step || NGROUPS == 1 || int'(grp_inc) == NGROUPS) begin
			rd_grp = 2'd0;
		end else begin
			rd_grp = grp_inc;
		end
	end

	always_comb begin
		res_word = '0;
		if (is_queue || is_step) begin
			for (int g = 0; g < NGROUPS; g++) begin
				if (int'(rd_grp) == g) begin
					for (int i = 0; i < BPW; i++) begin
						res_word[(BPW - 1 - i) * BW +: BW] = rd_w[g * BPW + i];
					end
				end
			end
		end
	end

	// Sticky nonzero-tile flag: set by a nonzero weight word, cleared by a step.
	always_comb begin
		flag_nxt = flag_q;
		if (is_write && cmd.data_word != '0) begin
			flag_nxt = 1'b1;
		end else if (is_step) begin
			flag_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (cmd_fire) begin
			flag_q <= flag_nxt;
		end
	end

	assign rsp_nxt.result_word = res_word;
	assign rsp_nxt.nonzero_tile = flag_nxt;

	// Response output register with one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || rsp_ready) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= cmd_fire;
			end
		end else if (cmd_fire) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || rsp_ready) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (cmd_fire) begin
				out_q <= rsp_nxt;
			end
		end else if (cmd_fire) begin
			skid_q <= rsp_nxt;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp = out_q;

endmodule

>>> rtl/wssa_checker.sv
module wssa_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input wssa_pkg::cmd_item_t cmd,
	input logic rsp_valid,
	input logic rsp_ready,
	input wssa_pkg::rsp_item_t rsp
);

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	// After an accepted command, rsp_valid is high in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> rsp_valid)
		else $error("accepted command produced no response");

	// Backpressure only while a response is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid)
		else $error("command channel stalled with no pending response");

	// Draining the output frees the skid entry.
	a_stall_clears: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready && rsp_ready |=> cmd_ready)
		else $error("command channel stayed stalled after a drain");

	// A nonzero weight word sets the flag and returns a zero word.
	a_weight_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !rsp_valid
		&& cmd.command == wssa_pkg::CMD_WRITE_WEIGHTS && cmd.data_word != '0
		|=> rsp.nonzero_tile && rsp.result_word == '0)
		else $error("weight write response is wrong");

endmodule

bind weight_stationary_systolic_mac_array wssa_checker u_wssa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.cmd(cmd),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);
